FILE: hw/rtl/pnts_pkg.sv
`default_nettype none
package pnts_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int MAX_CATEGORIES = 8;
  localparam int HANDLE_W = 32;
  localparam int CODE_W = 4;
  localparam int ORDER_SLOTS = 8;
  localparam int ORDER_W = ORDER_SLOTS * CODE_W;
  localparam int COUNT_W = 4;
  localparam int RANK_W = $clog2(ORDER_SLOTS);
  localparam int ACTIVE_SLOTS = (MAX_CATEGORIES < ORDER_SLOTS) ? MAX_CATEGORIES : ORDER_SLOTS;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_INDEX_W = 3;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_TARGET_FACTION = 3'd0,
    REG_CATEGORY_ORDER = 3'd1,
    REG_CATEGORY_COUNT = 3'd2,
    REG_ORIGIN_X       = 3'd3,
    REG_ORIGIN_Y       = 3'd4,
    REG_ORIGIN_Z       = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic              hit;
    logic [RANK_W-1:0] rank;
  } rank_match_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pnts_ifs.sv
`default_nettype none
interface pnts_cand_if #(
  parameter int COORD_BITS = pnts_pkg::COORD_BITS_DEF
) ();
  import pnts_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [HANDLE_W-1:0]          handle;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [CODE_W-1:0]            category;
  logic                         faction;
  logic                         last;

  modport source (output valid, handle, pos_x, pos_y, pos_z, category, faction, last,
                  input ready);
  modport sink (input valid, handle, pos_x, pos_y, pos_z, category, faction, last,
                output ready);
endinterface

interface pnts_result_if ();
  import pnts_pkg::*;

  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] target_handle;
  logic                found;

  modport source (output valid, target_handle, found, input ready);
  modport sink (input valid, target_handle, found, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pnts_rank_lookup.sv
`default_nettype none
module pnts_rank_lookup (
  input  wire logic [pnts_pkg::CODE_W-1:0]  category,
  input  wire logic [pnts_pkg::ORDER_W-1:0] category_order,
  input  wire logic [pnts_pkg::COUNT_W-1:0] category_count,
  output pnts_pkg::rank_match_t              match
);
  import pnts_pkg::*;

  logic [COUNT_W-1:0] slots_used;

  assign slots_used = (category_count > COUNT_W'(ACTIVE_SLOTS)) ?
                      COUNT_W'(ACTIVE_SLOTS) : category_count;

  // Walk from the highest slot down so that the lowest matching slot wins.
  always_comb begin
    match.hit  = 1'b0;
    match.rank = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if ((COUNT_W'(i) < slots_used) && (category_order[i*CODE_W +: CODE_W] == category)) begin
        match.hit  = 1'b1;
        match.rank = RANK_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/priority_nearest_target_select.sv
// Path: the last candidate of a scan passes the input register, the magnitude,
// square and sum stages and then the output register that holds the result word.
// Throughput: one candidate per cycle, the same in every stage and in the running
// best register, until a result held in the output register stalls a last word.
// Reset: synchronous; empties the pipeline and the output register, clears the
// running best and loads the register defaults (target faction 1, all else zero).
`default_nettype none
module priority_nearest_target_select #(
  parameter int COORD_BITS = pnts_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  pnts_cand_if.sink                            cand,
  pnts_result_if.source                        result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pnts_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pnts_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pnts_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import pnts_pkg::*;

  localparam int MAG_W = COORD_BITS;
  localparam int SQ_W = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 2;

  // Configuration registers.
  logic                  target_faction;
  logic [ORDER_W-1:0]    category_order;
  logic [COUNT_W-1:0]    category_count;
  logic [COORD_BITS-1:0] origin [3];

  reg_index_t reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_faction <= 1'b1;
      category_order <= '0;
      category_count <= '0;
      origin[0]      <= '0;
      origin[1]      <= '0;
      origin[2]      <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_TARGET_FACTION: target_faction <= pwdata[0];
        REG_CATEGORY_ORDER: category_order <= pwdata[ORDER_W-1:0];
        REG_CATEGORY_COUNT: category_count <= pwdata[COUNT_W-1:0];
        REG_ORIGIN_X:       origin[0] <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Y:       origin[1] <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Z:       origin[2] <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_TARGET_FACTION: prdata = APB_DATA_W'(target_faction);
      REG_CATEGORY_ORDER: prdata = APB_DATA_W'(category_order);
      REG_CATEGORY_COUNT: prdata = APB_DATA_W'(category_count);
      REG_ORIGIN_X:       prdata = APB_DATA_W'(origin[0]);
      REG_ORIGIN_Y:       prdata = APB_DATA_W'(origin[1]);
      REG_ORIGIN_Z:       prdata = APB_DATA_W'(origin[2]);
      default:            prdata = '0;
    endcase
  end

  // Pipeline registers.
  logic                  a_valid, b_valid, c_valid, d_valid;
  logic [HANDLE_W-1:0]   a_handle, b_handle, c_handle, d_handle;
  logic                  a_last, b_last, c_last, d_last;
  logic [COORD_BITS-1:0] a_pos [3];
  logic [CODE_W-1:0]     a_category;
  logic                  a_faction;
  logic                  b_qual, c_qual, d_qual;
  logic [RANK_W-1:0]     b_rank, c_rank, d_rank;
  logic [MAG_W-1:0]      b_mag [3];
  logic [SQ_W-1:0]       c_sq [3];
  logic [DIST_W-1:0]     d_dist;

  // Running best and output register.
  logic                have_best;
  logic [HANDLE_W-1:0] best_handle;
  logic [RANK_W-1:0]   best_rank;
  logic [DIST_W-1:0]   best_dist;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_handle;
  logic                out_found;

  logic d_take, adv_d, adv_c, adv_b, adv_a;

  // A last word may only leave stage d when the output register has room.
  assign d_take = d_valid && (!d_last || !out_valid || result.ready);
  assign adv_d  = !d_valid || d_take;
  assign adv_c  = !c_valid || adv_d;
  assign adv_b  = !b_valid || adv_c;
  assign adv_a  = !a_valid || adv_b;

  assign cand.ready = adv_a;

  rank_match_t a_match;
  logic [MAG_W-1:0] a_mag [3];

  pnts_rank_lookup u_rank_lookup (
    .category       (a_category),
    .category_order (category_order),
    .category_count (category_count),
    .match          (a_match)
  );

  always_comb begin
    logic [COORD_BITS:0] diff;
    logic [COORD_BITS:0] absd;
    for (int k = 0; k < 3; k++) begin
      diff = {a_pos[k][COORD_BITS-1], a_pos[k]} - {origin[k][COORD_BITS-1], origin[k]};
      absd = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
      // The difference of two in-range coordinates never reaches 2^COORD_BITS.
      a_mag[k] = absd[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (adv_a) a_valid <= cand.valid;
      if (adv_b) b_valid <= a_valid;
      if (adv_c) c_valid <= b_valid;
      if (adv_d) d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_handle   <= cand.handle;
      a_pos[0]   <= cand.pos_x;
      a_pos[1]   <= cand.pos_y;
      a_pos[2]   <= cand.pos_z;
      a_category <= cand.category;
      a_faction  <= cand.faction;
      a_last     <= cand.last;
    end
    if (adv_b) begin
      b_handle <= a_handle;
      b_last   <= a_last;
      b_qual   <= a_match.hit && (a_faction == target_faction);
      b_rank   <= a_match.rank;
      b_mag[0] <= a_mag[0];
      b_mag[1] <= a_mag[1];
      b_mag[2] <= a_mag[2];
    end
    if (adv_c) begin
      c_handle <= b_handle;
      c_last   <= b_last;
      c_qual   <= b_qual;
      c_rank   <= b_rank;
      c_sq[0]  <= SQ_W'(b_mag[0]) * SQ_W'(b_mag[0]);
      c_sq[1]  <= SQ_W'(b_mag[1]) * SQ_W'(b_mag[1]);
      c_sq[2]  <= SQ_W'(b_mag[2]) * SQ_W'(b_mag[2]);
    end
    if (adv_d) begin
      d_handle <= c_handle;
      d_last   <= c_last;
      d_qual   <= c_qual;
      d_rank   <= c_rank;
      d_dist   <= DIST_W'(c_sq[0]) + DIST_W'(c_sq[1]) + DIST_W'(c_sq[2]);
    end
  end

  // Best candidate so far, including the word now leaving stage d.
  logic                take;
  logic                have_best_next;
  logic [HANDLE_W-1:0] best_handle_next;
  logic [RANK_W-1:0]   best_rank_next;
  logic [DIST_W-1:0]   best_dist_next;

  always_comb begin
    priority if (!have_best) begin
      take = 1'b1;
    end else if (d_rank != best_rank) begin
      take = d_rank < best_rank;
    end else begin
      take = d_dist < best_dist;
    end
    if (d_qual && take) begin
      have_best_next   = 1'b1;
      best_handle_next = d_handle;
      best_rank_next   = d_rank;
      best_dist_next   = d_dist;
    end else begin
      have_best_next   = have_best;
      best_handle_next = best_handle;
      best_rank_next   = best_rank;
      best_dist_next   = best_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (d_take) begin
        have_best <= d_last ? 1'b0 : have_best_next;
      end
      if (d_take && d_last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_take) begin
      best_handle <= best_handle_next;
      best_rank   <= best_rank_next;
      best_dist   <= best_dist_next;
    end
    if (d_take && d_last) begin
      out_handle <= have_best_next ? best_handle_next : '0;
      out_found  <= have_best_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.target_handle = out_handle;
  assign result.found         = out_found;

  a_reset_empties_output: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid straight after reset");

  a_none_found_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.found) |-> (result.target_handle == '0))
    else $error("handle not zero although nothing was found");

  a_last_clears_search: assert property (@(posedge clk) disable iff (rst)
    (d_take && d_last) |=> (!have_best && result.valid))
    else $error("end of scan did not clear the search and raise a result");

  a_last_waits_for_room: assert property (@(posedge clk) disable iff (rst)
    (d_valid && d_last && result.valid && !result.ready) |-> !d_take)
    else $error("end of scan left stage d while the output register was full");

endmodule
`default_nettype wire
